### src/four_axis_sync_fault_monitor_macros.svh
// Assertion macros for the four-axis sync fault monitor.
// Used by the modules in src that check their own logic; needs clk and rst in scope.
`ifndef FOUR_AXIS_SYNC_FAULT_MONITOR_MACROS_SVH
`define FOUR_AXIS_SYNC_FAULT_MONITOR_MACROS_SVH

// Same-cycle implication.
`define FSFM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FSFM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/fsfm_pkg.sv
// Shared types and constants of the four-axis sync fault monitor.
// No dependencies; used by every module in src.
package fsfm_pkg;

  localparam int TRAVEL_W  = 32;
  localparam int CURRENT_W = 16;
  localparam int LINK_W    = 8;
  localparam int COUNT_W   = 5;
  localparam int SPREAD_W  = 32;
  localparam int SPREAD_LIMIT_W = 31;
  localparam int FAULT_AXIS_W   = 2;
  localparam int OUT_W     = 40;

  localparam logic [LINK_W-1:0]   LINK_LOSS_COUNT = 8'd10;
  localparam logic [COUNT_W-1:0]  STALL_TRIP      = 5'd20;
  localparam logic [COUNT_W-1:0]  STALL_MAX       = 5'd31;
  localparam logic [TRAVEL_W-1:0] SIGN_BIAS       = 32'h8000_0000;

  localparam logic [CURRENT_W-1:0]      STALL_LIMIT_RESET  = 16'd1000;
  localparam logic [SPREAD_LIMIT_W-1:0] SPREAD_LIMIT_RESET = 31'd750;

  typedef enum logic [1:0] {
    FAULT_SAFE   = 2'd0,
    FAULT_STALL  = 2'd1,
    FAULT_LINK   = 2'd2,
    FAULT_SPREAD = 2'd3
  } fault_code_t;

  typedef enum logic [0:0] {
    REG_STALL_LIMIT  = 1'b0,
    REG_SPREAD_LIMIT = 1'b1
  } reg_index_t;

endpackage

### src/fsfm_spread.sv
// Travel spread: min/max tree over the axis travels and their difference.
// Depends on fsfm_pkg.
module fsfm_spread #(
  parameter int AXES = 4
) (
  input  logic [AXES-1:0][fsfm_pkg::TRAVEL_W-1:0] travel,
  output logic [fsfm_pkg::SPREAD_W-1:0]           spread
);

  localparam int NP = 1 << $clog2(AXES);

  logic [fsfm_pkg::TRAVEL_W-1:0] lo_n [2*NP-1];
  logic [fsfm_pkg::TRAVEL_W-1:0] hi_n [2*NP-1];

  for (genvar j = 0; j < NP; j++) begin : g_leaf
    if (j < AXES) begin : g_real
      assign lo_n[NP-1+j] = travel[j] ^ fsfm_pkg::SIGN_BIAS;
      assign hi_n[NP-1+j] = travel[j] ^ fsfm_pkg::SIGN_BIAS;
    end else begin : g_pad
      assign lo_n[NP-1+j] = travel[0] ^ fsfm_pkg::SIGN_BIAS;
      assign hi_n[NP-1+j] = travel[0] ^ fsfm_pkg::SIGN_BIAS;
    end
  end

  for (genvar k = 0; k < NP-1; k++) begin : g_node
    assign lo_n[k] = (lo_n[2*k+1] < lo_n[2*k+2]) ? lo_n[2*k+1] : lo_n[2*k+2];
    assign hi_n[k] = (hi_n[2*k+1] > hi_n[2*k+2]) ? hi_n[2*k+1] : hi_n[2*k+2];
  end

  assign spread = hi_n[0] - lo_n[0];

endmodule

### src/fsfm_stall.sv
// Per-axis overcurrent stall counters with first-trip blocking of later axes.
// Depends on fsfm_pkg and the assertion macro header.
`include "four_axis_sync_fault_monitor_macros.svh"

module fsfm_stall #(
  parameter int AXES = 4,
  parameter int AXW  = 2
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     en,
  input  logic [AXES-1:0][fsfm_pkg::CURRENT_W-1:0] current,
  input  logic [fsfm_pkg::CURRENT_W-1:0]           limit,
  output logic                                     hit,
  output logic [AXW-1:0]                           axis
);

  logic [AXES-1:0][fsfm_pkg::COUNT_W-1:0] count;
  logic [AXES-1:0][fsfm_pkg::COUNT_W-1:0] count_next;
  logic [AXES-1:0][fsfm_pkg::COUNT_W-1:0] raised;
  logic [AXES-1:0]                        over;
  logic [AXES-1:0]                        trip;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      over[i]   = current[i] > limit;
      raised[i] = (count[i] == fsfm_pkg::STALL_MAX) ? count[i] : count[i] + 5'd1;
      trip[i]   = over[i] && (raised[i] >= fsfm_pkg::STALL_TRIP);
    end
  end

  always_comb begin
    hit  = |trip;
    axis = '0;
    for (int i = AXES - 1; i >= 0; i--) begin
      if (trip[i]) begin
        axis = AXW'(i);
      end
    end
  end

  always_comb begin
    logic blocked;
    blocked = 1'b0;
    for (int i = 0; i < AXES; i++) begin
      count_next[i] = count[i];
      if (en && !blocked) begin
        if (over[i]) begin
          count_next[i] = raised[i];
        end else if (count[i] != '0) begin
          count_next[i] = count[i] - 5'd1;
        end
      end
      blocked = blocked | trip[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  `FSFM_ASSERT_NEXT(a_count_hold, !en, $stable(count), "stall counters moved without a request")
  `FSFM_ASSERT_NEXT(a_trip_level, en && hit, count[$past(axis)] >= fsfm_pkg::STALL_TRIP,
    "stall reported on an axis below the trip level")

endmodule

### src/four_axis_sync_fault_monitor.sv
// Top level of the four-axis sync fault monitor: request registers, link and
// spread checks, fault priority. Depends on fsfm_pkg, fsfm_spread, fsfm_stall.
//
// One request per clock: a request taken on s_axis passes the request register and
// the result register to m_axis, at one per cycle while m_axis_tready stays high.
// The rate is set by the stall counters, read, updated and written back as a
// request moves from the request register to the result register. s_axis_tready
// follows m_axis_tready combinationally when both registers hold data. Stall
// counters clear on rst only; config must be written while idle (not enforced).
`include "four_axis_sync_fault_monitor_macros.svh"

module four_axis_sync_fault_monitor #(
  parameter int AXES = 4
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // travel_a.., current_a.., link_errors_a.. (lowest bit first)
  input  logic [AXES*(fsfm_pkg::TRAVEL_W+fsfm_pkg::CURRENT_W+fsfm_pkg::LINK_W)-1:0]
                                                s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // fault_code, fault_axis, travel_spread, zero pad (lowest bit first)
  output logic [fsfm_pkg::OUT_W-1:0]            m_axis_tdata,
  input  logic                                  cfg_we,
  input  logic [0:0]                            cfg_index,
  input  logic [fsfm_pkg::SPREAD_LIMIT_W-1:0]   cfg_wdata
);

  localparam int AXW  = $clog2(AXES);
  localparam int IN_W = AXES * (fsfm_pkg::TRAVEL_W + fsfm_pkg::CURRENT_W + fsfm_pkg::LINK_W);
  localparam int CUR_BASE  = AXES * fsfm_pkg::TRAVEL_W;
  localparam int LINK_BASE = AXES * (fsfm_pkg::TRAVEL_W + fsfm_pkg::CURRENT_W);

  logic [fsfm_pkg::CURRENT_W-1:0]      stall_current_limit;
  logic [fsfm_pkg::SPREAD_LIMIT_W-1:0] sync_spread_limit;

  logic            s0_valid;
  logic [IN_W-1:0] s0_data;
  logic            advance;

  logic                              m_valid;
  fsfm_pkg::fault_code_t             m_code;
  logic [fsfm_pkg::FAULT_AXIS_W-1:0] m_axis_idx;
  logic [fsfm_pkg::SPREAD_W-1:0]     m_spread;

  logic [AXES-1:0][fsfm_pkg::TRAVEL_W-1:0]  travel;
  logic [AXES-1:0][fsfm_pkg::CURRENT_W-1:0] current;
  logic [AXES-1:0][fsfm_pkg::LINK_W-1:0]    link_errors;

  logic [fsfm_pkg::SPREAD_W-1:0] spread;
  logic                          spread_over;
  logic                          link_hit;
  logic [AXW-1:0]                link_axis;
  logic                          stall_en;
  logic                          stall_hit;
  logic [AXW-1:0]                stall_axis;
  fsfm_pkg::fault_code_t         code_next;
  logic [AXW-1:0]                axis_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      stall_current_limit <= fsfm_pkg::STALL_LIMIT_RESET;
      sync_spread_limit   <= fsfm_pkg::SPREAD_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (fsfm_pkg::reg_index_t'(cfg_index))
        fsfm_pkg::REG_STALL_LIMIT:
          stall_current_limit <= cfg_wdata[fsfm_pkg::CURRENT_W-1:0];
        fsfm_pkg::REG_SPREAD_LIMIT:
          sync_spread_limit <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign advance       = s0_valid && (!m_valid || m_axis_tready);
  assign s_axis_tready = !s0_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s0_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s0_data <= s_axis_tdata;
    end
  end

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      travel[i]      = s0_data[i*fsfm_pkg::TRAVEL_W +: fsfm_pkg::TRAVEL_W];
      current[i]     = s0_data[CUR_BASE + i*fsfm_pkg::CURRENT_W +: fsfm_pkg::CURRENT_W];
      link_errors[i] = s0_data[LINK_BASE + i*fsfm_pkg::LINK_W +: fsfm_pkg::LINK_W];
    end
  end

  fsfm_spread #(
    .AXES (AXES)
  ) u_spread (
    .travel (travel),
    .spread (spread)
  );

  assign spread_over = spread > {1'b0, sync_spread_limit};

  always_comb begin
    link_hit  = 1'b0;
    link_axis = '0;
    for (int i = AXES - 1; i >= 0; i--) begin
      if (link_errors[i] >= fsfm_pkg::LINK_LOSS_COUNT) begin
        link_hit  = 1'b1;
        link_axis = AXW'(i);
      end
    end
  end

  assign stall_en = advance && !link_hit && !spread_over;

  fsfm_stall #(
    .AXES (AXES),
    .AXW  (AXW)
  ) u_stall (
    .clk     (clk),
    .rst     (rst),
    .en      (stall_en),
    .current (current),
    .limit   (stall_current_limit),
    .hit     (stall_hit),
    .axis    (stall_axis)
  );

  always_comb begin
    priority if (link_hit) begin
      code_next = fsfm_pkg::FAULT_LINK;
      axis_next = link_axis;
    end else if (spread_over) begin
      code_next = fsfm_pkg::FAULT_SPREAD;
      axis_next = '0;
    end else if (stall_hit) begin
      code_next = fsfm_pkg::FAULT_STALL;
      axis_next = stall_axis;
    end else begin
      code_next = fsfm_pkg::FAULT_SAFE;
      axis_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (advance) begin
      m_valid <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_code     <= code_next;
      m_axis_idx <= fsfm_pkg::FAULT_AXIS_W'(axis_next);
      m_spread   <= spread;
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {4'b0000, m_spread, m_axis_idx, m_code};

  `FSFM_ASSERT_SAME(a_axis_zero,
    m_valid && (m_code == fsfm_pkg::FAULT_SAFE || m_code == fsfm_pkg::FAULT_SPREAD),
    m_axis_idx == '0, "fault axis set on a safe or spread result")
  `FSFM_ASSERT_SAME(a_full_stall, s0_valid && m_valid && !m_axis_tready, !s_axis_tready,
    "request taken while both registers are full and stalled")
  `FSFM_ASSERT_NEXT(a_link_first, advance && link_hit,
    m_valid && m_code == fsfm_pkg::FAULT_LINK, "link loss not reported first")

endmodule

### sim/tb.sv
// Self-checking testbench for four_axis_sync_fault_monitor: directed ticks, then random
// ticks under several limit settings, with random idling on both stream sides.
// Depends on src/fsfm_pkg.sv and the RTL under src.
module tb;

  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_TICKS = 400;
  localparam logic [31:0] TMIN = 32'h8000_0000;
  localparam logic [31:0] TMAX = 32'h7FFF_FFFF;
  localparam logic [7:0] LINK_TRIP = 8'd10;
  localparam logic [4:0] STALL_FAULT_AT = 5'd20;
  localparam logic [4:0] STALL_CEIL = 5'd31;

  typedef struct packed {
    logic [31:0]  links;     // link_errors_d .. link_errors_a
    logic [63:0]  currents;  // current_d .. current_a
    logic [127:0] travels;   // travel_d .. travel_a
  } tick_t;

  typedef struct packed {
    fsfm_pkg::fault_code_t code;
    logic [1:0]            axis;
    logic [31:0]           spread;
  } fault_report_t;

  typedef struct {
    logic [127:0]          travels;
    logic [63:0]           currents;
    logic [31:0]           links;
    int                    reps;
    bit                    typed;
    fsfm_pkg::fault_code_t code;
    logic [1:0]            axis;
    logic [31:0]           spread;
  } drill_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic [223:0] s_tdata = '0;
  logic m_tready = 1'b0;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = fsfm_pkg::REG_STALL_LIMIT;
  logic [30:0] cfg_wdata = '0;
  logic s_axis_tready;
  logic m_axis_tvalid;
  logic [39:0] m_axis_tdata;

  logic [15:0] stall_lim = 16'd1000;
  logic [30:0] spread_lim = 31'd750;
  logic [4:0] stall_level [4] = '{default: 5'd0};
  logic [3:0] hot_axes = 4'd0;

  fault_report_t pending_reports [$];
  bit hold_pending = 1'b0;
  bit idle_on = 1'b1;
  int mismatches = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int code_seen [4] = '{default: 0};

  drill_row_t drill [19] = '{
    '{128'd0, 64'd0, 32'd0, 1, 1'b1, fsfm_pkg::FAULT_SAFE, 2'd0, 32'd0},
    '{{32'd0, 32'd0, TMAX, TMIN}, 64'd0, 32'd0, 1, 1'b1, fsfm_pkg::FAULT_SPREAD, 2'd0,
      32'hFFFF_FFFF},
    '{{TMAX, TMAX, TMAX, TMAX}, 64'd0, 32'd0, 1, 1'b1, fsfm_pkg::FAULT_SAFE, 2'd0, 32'd0},
    '{128'd0, 64'd0, {8'd0, 8'd10, 8'd0, 8'd0}, 1, 1'b1, fsfm_pkg::FAULT_LINK, 2'd2,
      32'd0},
    '{{32'd0, 32'd0, TMAX, TMIN}, 64'd0, 32'hFFFF_FFFF, 1, 1'b1, fsfm_pkg::FAULT_LINK,
      2'd0, 32'hFFFF_FFFF},
    '{{TMIN, TMIN, TMIN, TMIN}, 64'd0, {8'd10, 8'd9, 8'd9, 8'd9}, 1, 1'b1,
      fsfm_pkg::FAULT_LINK, 2'd3, 32'd0},
    '{{32'd0, 32'd0, 32'd750, 32'd0}, 64'd0, 32'd0, 1, 1'b1, fsfm_pkg::FAULT_SAFE, 2'd0,
      32'd750},
    '{{32'd0, 32'd0, 32'd751, 32'd0}, 64'd0, 32'd0, 1, 1'b1, fsfm_pkg::FAULT_SPREAD, 2'd0,
      32'd751},
    '{{32'd0, 32'd375, 32'd0, 32'hFFFF_FE89}, 64'd0, 32'd0, 1, 1'b1, fsfm_pkg::FAULT_SAFE,
      2'd0, 32'd750},
    '{128'd0, {4{16'd1000}}, 32'd0, 1, 1'b1, fsfm_pkg::FAULT_SAFE, 2'd0, 32'd0},
    '{128'd0, {16'd0, 16'd0, 16'd1001, 16'd0}, 32'd0, 19, 1'b0, fsfm_pkg::FAULT_SAFE,
      2'd0, 32'd0},
    '{128'd0, {16'd0, 16'd0, 16'd1001, 16'd0}, 32'd0, 1, 1'b1, fsfm_pkg::FAULT_STALL,
      2'd1, 32'd0},
    '{128'd0, {4{16'd1001}}, 32'd0, 1, 1'b1, fsfm_pkg::FAULT_STALL, 2'd1, 32'd0},
    '{128'd0, {16'd0, 16'd0, 16'hFFFF, 16'd0}, {8'd0, 8'd0, 8'd0, 8'd12}, 1, 1'b1,
      fsfm_pkg::FAULT_LINK, 2'd0, 32'd0},
    '{{32'd0, 32'd0, 32'd0, 32'd1000}, {16'd0, 16'd0, 16'hFFFF, 16'd0}, 32'd0, 1, 1'b1,
      fsfm_pkg::FAULT_SPREAD, 2'd0, 32'd1000},
    '{128'd0, 64'd0, 32'd0, 1, 1'b1, fsfm_pkg::FAULT_SAFE, 2'd0, 32'd0},
    '{128'd0, {16'd0, 16'd0, 16'd1001, 16'd0}, 32'd0, 1, 1'b1, fsfm_pkg::FAULT_STALL,
      2'd1, 32'd0},
    '{128'd0, {4{16'hFFFF}}, 32'd0, 1, 1'b0, fsfm_pkg::FAULT_SAFE, 2'd0, 32'd0},
    '{{4{32'hFFFF_FFFF}}, {4{16'hFFFF}}, 32'h0909_0909, 1, 1'b0, fsfm_pkg::FAULT_SAFE,
      2'd0, 32'd0}
  };

  four_axis_sync_fault_monitor u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),        // travel_a..d, current_a..d, link_errors_a..d
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata),   // fault_code, fault_axis, travel_spread, pad
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #(12 * 500000);
    $display("tb: timeout");
    $display("tb: done, errors");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("tb: mismatch: %s", what);
    mismatches++;
  endtask

  function automatic fault_report_t judge_tick(input tick_t t);
    fault_report_t r;
    logic [31:0] lo, hi, biased_t;
    bit done;
    r.code = fsfm_pkg::FAULT_SAFE;
    r.axis = 2'd0;
    lo = '1;
    hi = '0;
    for (int i = 0; i < 4; i++) begin
      biased_t = t.travels[32*i +: 32] ^ TMIN;
      if (biased_t < lo) lo = biased_t;
      if (biased_t > hi) hi = biased_t;
    end
    r.spread = hi - lo;
    for (int i = 0; i < 4 && r.code == fsfm_pkg::FAULT_SAFE; i++) begin
      if (t.links[8*i +: 8] >= LINK_TRIP) begin
        r.code = fsfm_pkg::FAULT_LINK;
        r.axis = 2'(i);
      end
    end
    if (r.code == fsfm_pkg::FAULT_SAFE && r.spread > {1'b0, spread_lim})
      r.code = fsfm_pkg::FAULT_SPREAD;
    if (r.code == fsfm_pkg::FAULT_SAFE) begin
      done = 1'b0;
      for (int i = 0; i < 4 && !done; i++) begin
        if (t.currents[16*i +: 16] > stall_lim) begin
          if (stall_level[i] < STALL_CEIL) stall_level[i]++;
          if (stall_level[i] >= STALL_FAULT_AT) begin
            r.code = fsfm_pkg::FAULT_STALL;
            r.axis = 2'(i);
            done = 1'b1;
          end
        end else if (stall_level[i] != 5'd0) begin
          stall_level[i]--;
        end
      end
    end
    return r;
  endfunction

  function automatic tick_t make_tick();
    tick_t t;
    logic [31:0] base, span;
    int ax;
    if ($urandom_range(0, 9) == 0) begin
      t.travels = {$urandom, $urandom, $urandom, $urandom};
      t.currents = {$urandom, $urandom};
      t.links = $urandom;
      return t;
    end
    if ($urandom_range(0, 23) == 0) hot_axes = 4'($urandom);
    base = $urandom;
    case ($urandom_range(0, 3))
      0: span = 32'd0;
      1: span = {1'b0, spread_lim};
      2: span = {1'b0, spread_lim} + 32'd1 + $urandom_range(0, 63);
      default: span = $urandom_range(0, 2000);
    endcase
    t.links = '0;
    for (int i = 0; i < 4; i++) begin
      t.travels[32*i +: 32] = base + $urandom_range(0, span);
      if (hot_axes[i] && stall_lim != 16'hFFFF)
        t.currents[16*i +: 16] = 16'($urandom_range(stall_lim + 1, 65535));
      else
        t.currents[16*i +: 16] = 16'($urandom_range(0, stall_lim));
      t.links[8*i +: 8] = 8'($urandom_range(0, 9));
    end
    if ($urandom_range(0, 19) == 0) begin
      ax = $urandom_range(0, 3);
      t.links[8*ax +: 8] = 8'($urandom_range(10, 255));
    end
    return t;
  endfunction

  task automatic send_tick(input tick_t t, input bit typed, input fault_report_t want);
    fault_report_t predicted;
    s_tvalid <= 1'b1;
    s_tdata <= t;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predicted = judge_tick(t);
    pending_reports.push_back(typed ? want : predicted);
    requests_sent++;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic settle();
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limits(input logic [15:0] stall, input logic [30:0] spread);
    cfg_we <= 1'b1;
    cfg_index <= fsfm_pkg::REG_STALL_LIMIT;
    cfg_wdata <= {15'd0, stall};
    @(posedge clk);
    cfg_index <= fsfm_pkg::REG_SPREAD_LIMIT;
    cfg_wdata <= spread;
    @(posedge clk);
    cfg_we <= 1'b0;
    stall_lim = stall;
    spread_lim = spread;
  endtask

  // receiver side: random stalls, plus one long hold-off on request
  initial begin
    wait (!rst);
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        m_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    fault_report_t want;
    if (!rst && m_axis_tvalid && m_tready) begin
      results_checked++;
      code_seen[m_axis_tdata[1:0]]++;
      if (pending_reports.size() == 0) begin
        report_mismatch("result with nothing pending");
      end else begin
        want = pending_reports.pop_front();
        if (m_axis_tdata[1:0] !== want.code)
          report_mismatch($sformatf("fault_code %0d, want %0d", m_axis_tdata[1:0], want.code));
        if (m_axis_tdata[3:2] !== want.axis)
          report_mismatch($sformatf("fault_axis %0d, want %0d", m_axis_tdata[3:2], want.axis));
        if (m_axis_tdata[35:4] !== want.spread)
          report_mismatch($sformatf("travel_spread %h, want %h", m_axis_tdata[35:4],
                                    want.spread));
      end
    end
  end

  initial begin
    logic [15:0] phase_stall [5];
    logic [30:0] phase_spread [5];
    fault_report_t want;
    drill_row_t row;
    int n;
    phase_stall = '{16'd0, 16'hFFFF, 16'($urandom_range(0, 65535)), 16'd500, 16'd1000};
    phase_spread = '{31'd0, 31'h7FFF_FFFF, 31'($urandom_range(0, 5000)), 31'd100000,
                     31'd750};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (drill[k]) begin
      row = drill[k];
      want.code = row.code;
      want.axis = row.axis;
      want.spread = row.spread;
      repeat (row.reps) send_tick(tick_t'({row.links, row.currents, row.travels}), row.typed,
                                  want);
    end
    s_tvalid <= 1'b0;

    for (int p = 0; p < 5; p++) begin
      settle();
      set_limits(phase_stall[p], phase_spread[p]);
      if (p == 2) hold_pending = 1'b1;
      if (p == 4) idle_on = 1'b0;
      repeat (PHASE_TICKS) send_tick(make_tick(), 1'b0, want);
      s_tvalid <= 1'b0;
    end

    n = 0;
    while (pending_reports.size() != 0 && n < 20000) begin
      @(posedge clk);
      n++;
    end
    repeat (8) @(posedge clk);
    if (pending_reports.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_reports.size()));

    $display("tb: %0d ticks sent (directed set, then 5 limit settings incl. extremes), %0d checked",
             requests_sent, results_checked);
    $display("tb: results seen: safe %0d, stall %0d, link %0d, spread %0d",
             code_seen[fsfm_pkg::FAULT_SAFE], code_seen[fsfm_pkg::FAULT_STALL],
             code_seen[fsfm_pkg::FAULT_LINK], code_seen[fsfm_pkg::FAULT_SPREAD]);
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule

### files.f
+incdir+src
src/fsfm_pkg.sv
src/fsfm_spread.sv
src/fsfm_stall.sv
src/four_axis_sync_fault_monitor.sv
sim/tb.sv
